>>> design/key_matrix_scan_report_core_defines.svh
// Assertion macros shared by the checker.
`ifndef KEY_MATRIX_SCAN_REPORT_CORE_DEFINES_SVH
`define KEY_MATRIX_SCAN_REPORT_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define KMSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define KMSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/kmsr_pkg.sv
`default_nettype none
package kmsr_pkg;

    localparam int LEVEL_W   = 25;
    localparam int SLOT_N    = 6;
    localparam int CODE_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int TABLE_DIM = 5;
    localparam int MAP_LIMIT = 64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } kmsr_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } kmsr_ctrl_t;

    typedef struct packed {
        logic              map_next;
        logic              changed;
        logic              keep;
        logic [CODE_W-1:0] code;
    } kmsr_eval_t;

    typedef logic [CODE_W-1:0] code_row_t [TABLE_DIM];

    localparam code_row_t CODE_TABLE [TABLE_DIM] = '{
        '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21},
        '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15},
        '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09},
        '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19},
        '{8'hE0, 8'hE3, 8'hE2, 8'h2C, 8'h00}
    };

    function automatic logic [CODE_W-1:0] code_at(input logic [7:0] row, input logic [7:0] col);
        logic [CODE_W-1:0] code;
        code = '0;
        if (row < 8'(TABLE_DIM) && col < 8'(TABLE_DIM))
        begin
            code = CODE_TABLE[row[2:0]][col[2:0]];
        end
        return code;
    endfunction

    // Positions past the sampled word read as low.
    function automatic logic level_at(input logic [LEVEL_W-1:0] levels, input logic [7:0] idx);
        logic bit_val;
        bit_val = 1'b0;
        if (idx < 8'(LEVEL_W))
        begin
            bit_val = levels[idx[4:0]];
        end
        return bit_val;
    endfunction

endpackage
`default_nettype wire

>>> design/kmsr_key_unit.sv
`default_nettype none
module kmsr_key_unit
    import kmsr_pkg::*;
(
    input  wire logic               first_bit,
    input  wire logic               confirm_bit,
    input  wire logic               map_bit,
    input  wire logic               in_range,
    input  wire logic [7:0]         row,
    input  wire logic [7:0]         col,
    output kmsr_eval_t              eval
);

    always_comb
    begin
        eval.map_next = map_bit;
        eval.changed  = 1'b0;
        eval.keep     = 1'b0;
        eval.code     = code_at(row, col);
        if (in_range)
        begin
            if (!first_bit)
            begin
                if (map_bit)
                begin
                    eval.keep = 1'b1;
                end
                else if (!confirm_bit)
                begin
                    eval.map_next = 1'b1;
                    eval.changed  = 1'b1;
                    eval.keep     = 1'b1;
                end
            end
            else if (map_bit)
            begin
                eval.map_next = 1'b0;
                eval.changed  = 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/kmsr_ctrl.sv
`default_nettype none
module kmsr_ctrl
    import kmsr_pkg::*;
#(
    parameter int ROWS  = 5,
    parameter int COLS  = 5,
    parameter int RW    = 3,
    parameter int CW    = 3,
    parameter int IDX_W = 5
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             out_busy,
    output logic                  in_stall,
    output kmsr_ctrl_t            ctrl,
    output logic [RW-1:0]         row,
    output logic [CW-1:0]         col,
    output logic [IDX_W-1:0]      idx
);

    kmsr_state_t      state_reg, state_next;
    logic [RW-1:0]    row_reg, row_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_key;

    assign row = row_reg;
    assign col = col_reg;
    assign idx = idx_reg;
    assign last_key = (row_reg == RW'(ROWS - 1)) && (col_reg == CW'(COLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        idx_next    = idx_reg;
        ctrl        = '0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    row_next   = '0;
                    col_next   = '0;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                ctrl.step = 1'b1;
                if (last_key)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (row_reg == RW'(ROWS - 1))
                    begin
                        row_next = '0;
                        col_next = col_reg + 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                if (!out_busy)
                begin
                    ctrl.finish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/key_matrix_scan_report_core.sv
`default_nettype none
// Scan-to-report core for a ROWS x COLS key matrix. Each input beat carries one full scan
// as two active-low samples (first read, confirm read); each output beat is a six-slot
// keycode report with key count and a changed flag. One shared key evaluator walks the
// keys column-major, one key per cycle. A scan passes through an accept step,
// an evaluation step per key and a load of the output register; the load waits while the
// output side holds a previous report. in_stall is high from accept until the result is
// loaded; a finished report waits in the output register while the next scan is taken.
module key_matrix_scan_report_core
    import kmsr_pkg::*;
#(
    parameter int ROWS        = 5,
    parameter int COLS        = 5,
    parameter int REPORT_KEYS = 6
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [LEVEL_W-1:0] first_levels,
    input  wire logic [LEVEL_W-1:0] confirm_levels,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [CODE_W-1:0]       key_slot_a,
    output logic [CODE_W-1:0]       key_slot_b,
    output logic [CODE_W-1:0]       key_slot_c,
    output logic [CODE_W-1:0]       key_slot_d,
    output logic [CODE_W-1:0]       key_slot_e,
    output logic [CODE_W-1:0]       key_slot_f,
    output logic [COUNT_W-1:0]      key_count,
    output logic                    report_changed
);

    localparam int KEYS  = ROWS * COLS;
    localparam int IDX_W = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;

    kmsr_ctrl_t         ctrl;
    kmsr_eval_t         eval;
    logic [RW-1:0]      row;
    logic [CW-1:0]      col;
    logic [IDX_W-1:0]   idx;
    logic [7:0]         idx8;

    logic [LEVEL_W-1:0] first_reg;
    logic [LEVEL_W-1:0] confirm_reg;
    logic [KEYS-1:0]    map_reg;
    logic [CODE_W-1:0]  slot_reg [SLOT_N];
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] last_count_reg;
    logic               chg_reg;

    logic               out_valid_reg;
    logic [CODE_W-1:0]  out_slot_reg [SLOT_N];
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_chg_reg;

    assign idx8 = 8'(idx);

    kmsr_ctrl #(
        .ROWS  (ROWS),
        .COLS  (COLS),
        .RW    (RW),
        .CW    (CW),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_busy (out_valid_reg && out_stall),
        .in_stall (in_stall),
        .ctrl     (ctrl),
        .row      (row),
        .col      (col),
        .idx      (idx)
    );

    kmsr_key_unit u_key (
        .first_bit   (level_at(first_reg, idx8)),
        .confirm_bit (level_at(confirm_reg, idx8)),
        .map_bit     (map_reg[idx]),
        .in_range    (idx8 < 8'(MAP_LIMIT)),
        .row         (8'(row)),
        .col         (8'(col)),
        .eval        (eval)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            first_reg   <= first_levels;
            confirm_reg <= confirm_levels;
            for (int i = 0; i < SLOT_N; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else if (ctrl.step && eval.keep && cnt_reg < COUNT_W'(REPORT_KEYS))
        begin
            slot_reg[cnt_reg] <= eval.code;
        end
        if (ctrl.finish)
        begin
            out_slot_reg  <= slot_reg;
            out_count_reg <= cnt_reg;
            out_chg_reg   <= chg_reg || (cnt_reg != last_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= '0;
            cnt_reg        <= '0;
            chg_reg        <= 1'b0;
            last_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                cnt_reg <= '0;
                chg_reg <= 1'b0;
            end
            else if (ctrl.step)
            begin
                map_reg[idx] <= eval.map_next;
                chg_reg      <= chg_reg || eval.changed;
                if (eval.keep && cnt_reg < COUNT_W'(REPORT_KEYS))
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (ctrl.finish)
            begin
                last_count_reg <= cnt_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign key_slot_a     = out_slot_reg[0];
    assign key_slot_b     = out_slot_reg[1];
    assign key_slot_c     = out_slot_reg[2];
    assign key_slot_d     = out_slot_reg[3];
    assign key_slot_e     = out_slot_reg[4];
    assign key_slot_f     = out_slot_reg[5];
    assign key_count      = out_count_reg;
    assign report_changed = out_chg_reg;

endmodule
`default_nettype wire

>>> design/kmsr_checker.sv
`default_nettype none
`include "key_matrix_scan_report_core_defines.svh"
module kmsr_checker
    import kmsr_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [CODE_W-1:0]  key_slot_a,
    input wire logic [CODE_W-1:0]  key_slot_b,
    input wire logic [CODE_W-1:0]  key_slot_c,
    input wire logic [CODE_W-1:0]  key_slot_d,
    input wire logic [CODE_W-1:0]  key_slot_e,
    input wire logic [CODE_W-1:0]  key_slot_f,
    input wire logic [COUNT_W-1:0] key_count,
    input wire logic               report_changed
);

    `KMSR_ASSERT_NOW(a_count_cap, out_valid, key_count <= 3'(SLOT_N), "key_count above six")

    `KMSR_ASSERT_NOW(a_empty_report, out_valid && key_count == 3'd0,
        key_slot_a == 8'h00 && key_slot_b == 8'h00 && key_slot_c == 8'h00 &&
        key_slot_d == 8'h00 && key_slot_e == 8'h00 && key_slot_f == 8'h00 &&
        report_changed == report_changed, "empty report has a nonzero slot")

    `KMSR_ASSERT_NOW(a_tail_zero, out_valid && key_count < 3'(SLOT_N),
        key_slot_f == 8'h00, "slot past key_count is nonzero")

    `KMSR_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "scan accepted without going busy")

    `KMSR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid,
        "stalled report dropped")

endmodule

bind key_matrix_scan_report_core kmsr_checker u_kmsr_checker (.*);
`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import kmsr_pkg::*;

    localparam int MATRIX_DIM = 5;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES = 64;
    localparam int MAX_GAP = 20;
    localparam int SCANS_PER_PHASE = 500;

    typedef struct packed {
        logic [SLOT_N-1:0][CODE_W-1:0] slots;
        logic [COUNT_W-1:0]            count;
        logic                          changed;
    } key_report_t;

    class key_report_board;
        logic [CODE_W-1:0]  keycode [MATRIX_DIM][MATRIX_DIM];
        logic [LEVEL_W-1:0] held_keys;
        logic [COUNT_W-1:0] last_reported;
        key_report_t        expected_reports[$];
        int                 errors;

        function new();
            keycode = '{
                '{8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21},
                '{8'h2B, 8'h14, 8'h1A, 8'h08, 8'h15},
                '{8'h39, 8'h04, 8'h16, 8'h07, 8'h09},
                '{8'hE1, 8'h1D, 8'h1B, 8'h06, 8'h19},
                '{8'hE0, 8'hE3, 8'hE2, 8'h2C, 8'h00}
            };
            held_keys = '0;
            last_reported = '0;
            errors = 0;
        endfunction

        function void note_scan(input logic [LEVEL_W-1:0] first, input logic [LEVEL_W-1:0] confirm);
            key_report_t rep;
            int          idx;
            int          n;
            logic        keep;
            rep = '0;
            n = 0;
            for (int col = 0; col < MATRIX_DIM; col++)
            begin
                for (int row = 0; row < MATRIX_DIM; row++)
                begin
                    idx = col * MATRIX_DIM + row;
                    keep = 1'b0;
                    if (!first[idx])
                    begin
                        if (held_keys[idx])
                        begin
                            keep = 1'b1;
                        end
                        else if (!confirm[idx])
                        begin
                            held_keys[idx] = 1'b1;
                            rep.changed = 1'b1;
                            keep = 1'b1;
                        end
                    end
                    else if (held_keys[idx])
                    begin
                        held_keys[idx] = 1'b0;
                        rep.changed = 1'b1;
                    end
                    if (keep && n < SLOT_N)
                    begin
                        rep.slots[n] = keycode[row][col];
                        n++;
                    end
                end
            end
            rep.count = COUNT_W'(n);
            if (rep.count != last_reported)
            begin
                rep.changed = 1'b1;
            end
            last_reported = rep.count;
            expected_reports.push_back(rep);
        endfunction

        function void check_report(input key_report_t got);
            key_report_t want;
            string       names[SLOT_N];
            names = '{"key_slot_a", "key_slot_b", "key_slot_c",
                      "key_slot_d", "key_slot_e", "key_slot_f"};
            if (expected_reports.size() == 0)
            begin
                $error("report beat with no scan pending");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            for (int j = 0; j < SLOT_N; j++)
            begin
                if (got.slots[j] !== want.slots[j])
                begin
                    $error("%s: expected %02h, got %02h", names[j], want.slots[j], got.slots[j]);
                    errors++;
                end
            end
            if (got.count !== want.count)
            begin
                $error("key_count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.changed !== want.changed)
            begin
                $error("report_changed: expected %0d, got %0d", want.changed, got.changed);
                errors++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [LEVEL_W-1:0] first_levels = '1;
    logic [LEVEL_W-1:0] confirm_levels = '1;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [CODE_W-1:0]  key_slot_a;
    logic [CODE_W-1:0]  key_slot_b;
    logic [CODE_W-1:0]  key_slot_c;
    logic [CODE_W-1:0]  key_slot_d;
    logic [CODE_W-1:0]  key_slot_e;
    logic [CODE_W-1:0]  key_slot_f;
    logic [COUNT_W-1:0] key_count;
    logic               report_changed;

    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 quiet_cycles = 0;
    logic [LEVEL_W-1:0] keys_down = '0;
    key_report_board    board = new();

    key_matrix_scan_report_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_levels   (first_levels),
        .confirm_levels (confirm_levels),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .key_slot_a     (key_slot_a),
        .key_slot_b     (key_slot_b),
        .key_slot_c     (key_slot_c),
        .key_slot_d     (key_slot_d),
        .key_slot_e     (key_slot_e),
        .key_slot_f     (key_slot_f),
        .key_count      (key_count),
        .report_changed (report_changed)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : report_monitor
        key_report_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.slots[0] = key_slot_a;
            got.slots[1] = key_slot_b;
            got.slots[2] = key_slot_c;
            got.slots[3] = key_slot_d;
            got.slots[4] = key_slot_e;
            got.slots[5] = key_slot_f;
            got.count = key_count;
            got.changed = report_changed;
            board.check_report(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_scan(input logic [LEVEL_W-1:0] first, input logic [LEVEL_W-1:0] confirm);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        first_levels <= first;
        confirm_levels <= confirm;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_scan(first, confirm);
    endtask

    task automatic drain_reports();
        in_valid <= 1'b0;
        while (board.expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_directed();
        send_scan('1, '1);
        send_scan('0, '0);
        send_scan('0, '1);
        send_scan('0, '0);
        send_scan('1, '1);
        send_scan('0, '1);
        send_scan(~(25'd1 << 24), ~(25'd1 << 24));
        // hold the no-code key, press all modifiers
        send_scan(~25'h1004218, ~25'h0004218);
        send_scan(~25'h1004218, ~25'h0004218);
        send_scan(~25'h0004218, '1);
        send_scan(~25'h000007F, ~25'h000007F);
        send_scan(~25'h000007E, '1);
        send_scan(~25'h000003E, '0);
        send_scan(~25'h0100001, ~25'h0000001);
        send_scan('1, '0);
        send_scan(~25'h1000000, '1);
        send_scan('0, '0);
        send_scan('1, '1);
    endtask

    task automatic send_random(input int n);
        logic [LEVEL_W-1:0] first;
        logic [LEVEL_W-1:0] confirm;
        int                 pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                repeat ($urandom_range(0, 2)) keys_down[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
                if ($countones(keys_down) > 9)
                begin
                    keys_down &= LEVEL_W'($urandom);
                end
                first = ~keys_down;
                if ($urandom_range(0, 9) == 0)
                begin
                    first ^= LEVEL_W'($urandom & $urandom & $urandom);
                end
                confirm = ~keys_down ^ LEVEL_W'($urandom & $urandom & $urandom & $urandom);
            end
            else if (pick < 90)
            begin
                first = LEVEL_W'($urandom);
                confirm = LEVEL_W'($urandom);
            end
            else
            begin
                first = LEVEL_W'($urandom & $urandom);
                confirm = LEVEL_W'($urandom & $urandom);
            end
            send_scan(first, confirm);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_directed();
        send_random(SCANS_PER_PHASE);
        drain_reports();

        send_idle_pct = 55;
        recv_stall_pct = 0;
        send_random(SCANS_PER_PHASE);
        drain_reports();

        send_idle_pct = 0;
        recv_stall_pct = 55;
        send_random(SCANS_PER_PHASE);
        drain_reports();

        send_idle_pct = 26;
        recv_stall_pct = 26;
        send_random(SCANS_PER_PHASE);
        drain_reports();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.expected_reports.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
